// ===== design/macd_pkg.sv =====
// ----------------------------------------------------------------------------
// macd_pkg - shared types and fixed constants for the MACD crossover block
// Field widths, fixed-point formats, sequencer state codes and the
// elaboration-time helpers used to build the weight tables.
// ----------------------------------------------------------------------------
`default_nettype none

package macd_pkg;

  // Field and datapath widths
  localparam int DATA_W   = 32;              // price / macd / signal words
  localparam int W_W      = 19;              // Q0.18 weight or reciprocal, up to 2^18
  localparam int PROD_W   = DATA_W + W_W;    // one tap product
  localparam int ACC_W    = 58;              // signed tap accumulator
  localparam int MAG_W    = ACC_W - 1;       // accumulator magnitude
  localparam int HI_W     = MAG_W - DATA_W;  // upper slice of the magnitude
  localparam int SUM_W    = PROD_W + DATA_W; // recombined scale product
  localparam int RND_SH   = 36;              // scale product is Q36
  localparam int RES_W    = 40;              // magnitude of one average
  localparam int DIFF_W   = RES_W + 2;       // signed fast minus slow
  localparam int IN_TW    = 32;              // input tdata width
  localparam int OUT_TW   = 72;              // result tdata width, whole bytes
  localparam int OUT_PAD  = OUT_TW - 2 * DATA_W - 2;

  localparam logic [63:0] ONE_Q18 = 64'd262144;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_SUM,
    ST_FINISH
  } state_t;

  // Which average is being worked on
  typedef enum logic [1:0] {
    PH_FAST,
    PH_SLOW,
    PH_SIG
  } phase_t;

  // Relation of macd to signal on the last item
  typedef enum logic [1:0] {
    REL_NONE  = 2'd0,
    REL_BELOW = 2'd1,
    REL_EQUAL = 2'd2,
    REL_ABOVE = 2'd3
  } rel_t;

  // Restoring long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
    logic signed [DATA_W-1:0] s;
    if (v > 42'sh000_7FFF_FFFF) begin
      s = 32'sh7FFF_FFFF;
    end else if (v < 42'sh3FF_8000_0000) begin
      s = 32'sh8000_0000;
    end else begin
      s = v[DATA_W-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/macd_signal_crossover.sv =====
// ----------------------------------------------------------------------------
// macd_signal_crossover - MACD with signal line and crossover flags
// Each item runs the fast, slow and signal averages in turn over mf + 1, ms + 1
//   and mg + 1 taps, where mf, ms, mg = min(items seen, FAST_LEN / SLOW_LEN / SIGNAL_LEN).
// A new item is taken only in idle, after the last result is in the output register;
//   all taps go through the single shared 32x19 multiplier, one tap a cycle.
// Reset: synchronous, clears sequencer, counters and pointers; history memories
//   are not cleared, only entries written since reset are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_signal_crossover #(
  parameter int FAST_LEN   = 12,
  parameter int SLOW_LEN   = 26,
  parameter int SIGNAL_LEN = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [macd_pkg::IN_TW-1:0]    in_tdata,   // [31:0] price
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [macd_pkg::OUT_TW-1:0]        out_tdata   // [31:0] macd_value,
                                                         // [63:32] signal_value,
                                                         // [64] cross_down,
                                                         // [65] cross_up, rest 0
);

  import macd_pkg::*;

  localparam int PRICE_DEPTH = (FAST_LEN > SLOW_LEN) ? FAST_LEN : SLOW_LEN;
  localparam int SEEN_MAX    = (PRICE_DEPTH > SIGNAL_LEN) ? PRICE_DEPTH : SIGNAL_LEN;
  localparam int NROW        = SEEN_MAX + 1;
  localparam int SW          = $clog2(NROW);
  localparam int PA          = $clog2(PRICE_DEPTH);
  localparam int GA          = $clog2(SIGNAL_LEN);

  typedef logic [NROW-1:0][NROW-1:0][W_W-1:0] wtab_t;
  typedef logic [NROW-1:0][W_W-1:0]           rtab_t;

  // Weight rows: W[m][i] = round(W[m][i-1] * (m-1)/(m+1)), Q0.18
  function automatic wtab_t build_wtab();
    wtab_t       t;
    logic [63:0] num;
    t = '0;
    for (int m = 0; m < NROW; m++) begin
      t[m][0] = W_W'(ONE_Q18);
      if (m >= 2) begin
        for (int i = 1; i <= m; i++) begin
          num     = 64'(t[m][i-1]) * 64'(2 * (m - 1)) + 64'(m + 1);
          t[m][i] = W_W'(udiv64(num, 64'(2 * (m + 1))));
        end
      end
    end
    return t;
  endfunction

  // Reciprocal of each row sum, round(2^36 / S[m])
  function automatic rtab_t build_rtab(input wtab_t w);
    rtab_t       t;
    logic [63:0] sum;
    logic [63:0] q;
    t = '0;
    for (int m = 0; m < NROW; m++) begin
      sum = '0;
      for (int i = 0; i <= m; i++) begin
        sum = sum + 64'(w[m][i]);
      end
      q    = (udiv64(64'd1 << 37, sum) + 64'd1) >> 1;
      t[m] = W_W'(q);
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();
  localparam rtab_t RTAB = build_rtab(WTAB);

  localparam logic [SW-1:0] FAST_M   = SW'(FAST_LEN);
  localparam logic [SW-1:0] SLOW_M   = SW'(SLOW_LEN);
  localparam logic [SW-1:0] SIG_M    = SW'(SIGNAL_LEN);
  localparam logic [SW-1:0] SEEN_TOP = SW'(SEEN_MAX);
  localparam logic [PA-1:0] P_LAST   = PA'(PRICE_DEPTH - 1);
  localparam logic [GA-1:0] G_LAST   = GA'(SIGNAL_LEN - 1);

  // History memories, circular, one write and one read port each
  logic [DATA_W-1:0] pmem [PRICE_DEPTH];
  logic [DATA_W-1:0] gmem [SIGNAL_LEN];

  // Control state
  state_t          state_r, state_nxt;
  phase_t          phase_r;
  rel_t            prev_rel_r;
  logic [SW-1:0]   seen_r;
  logic [PA-1:0]   pwp_r;
  logic [GA-1:0]   gwp_r;
  logic            s1_vld_r;
  logic            s2_vld_r;
  logic            out_tvalid_r;

  // Payload and datapath
  logic [SW-1:0]              m_r;
  logic [SW-1:0]              i_r;
  logic [PA-1:0]              prp_r;
  logic [GA-1:0]              grp_r;
  logic [DATA_W-1:0]          cur_r;
  logic [DATA_W-1:0]          pmem_q_r;
  logic [DATA_W-1:0]          gmem_q_r;
  logic [W_W-1:0]             w_q_r;
  logic                       s1_first_r;
  logic [PROD_W-1:0]          prod_r;
  logic [PROD_W-1:0]          prod_lo_r;
  logic                       s2_neg_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic signed [RES_W:0]      fast_r;
  logic signed [DATA_W-1:0]   macd_r;
  logic signed [DATA_W-1:0]   sig_r;
  logic [OUT_TW-1:0]          out_tdata_r;

  // Combinational helpers
  logic                       in_take;
  logic                       out_free;
  logic                       pipe_empty;
  logic                       setup;
  phase_t                     ph_next;
  logic [SW-1:0]              m_next;
  logic signed [DATA_W-1:0]   tap_v;
  logic                       tap_neg;
  logic [DATA_W-1:0]          tap_mag;
  logic [DATA_W-1:0]          mul_a;
  logic [W_W-1:0]             mul_b;
  logic [PROD_W-1:0]          mul_p;
  logic [ACC_W-1:0]           acc_abs;
  logic [SUM_W-1:0]           scale_sum;
  logic [RES_W-1:0]           res_mag;
  logic signed [RES_W:0]      avg_s;
  logic signed [DATA_W-1:0]   avg_sat;
  logic signed [DATA_W-1:0]   diff_sat;
  rel_t                       rel_now;
  logic                       cross_dn;
  logic                       cross_up;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign in_take    = in_tvalid && (state_r == ST_IDLE);
  assign out_free   = !out_tvalid_r || out_tready;
  assign pipe_empty = !s1_vld_r && !s2_vld_r;

  // Sequencer: next state and phase setup
  always_comb begin
    state_nxt = state_r;
    setup     = 1'b0;
    ph_next   = PH_FAST;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_ISSUE;
          setup     = 1'b1;
        end
      end
      ST_ISSUE: begin
        if (i_r == m_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_SC_LO;
        end
      end
      ST_SC_LO: begin
        state_nxt = ST_SC_HI;
      end
      ST_SC_HI: begin
        state_nxt = ST_SC_SUM;
      end
      ST_SC_SUM: begin
        if (phase_r == PH_SIG) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_ISSUE;
          setup     = 1'b1;
          ph_next   = (phase_r == PH_FAST) ? PH_SLOW : PH_SIG;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Window length for the phase about to start
  always_comb begin
    case (ph_next)
      PH_FAST: m_next = (seen_r < FAST_M) ? seen_r : FAST_M;
      PH_SLOW: m_next = (seen_r < SLOW_M) ? seen_r : SLOW_M;
      PH_SIG:  m_next = (seen_r < SIG_M) ? seen_r : SIG_M;
      default: m_next = '0;
    endcase
  end

  // Tap operand: current value first, then history
  always_comb begin
    if (phase_r == PH_SIG) begin
      tap_v = s1_first_r ? macd_r : $signed(gmem_q_r);
    end else begin
      tap_v = s1_first_r ? $signed(cur_r) : $signed(pmem_q_r);
    end
    tap_neg = (phase_r == PH_SIG) && tap_v[DATA_W-1];
    tap_mag = tap_neg ? (DATA_W'(0) - DATA_W'(tap_v)) : DATA_W'(tap_v);
  end

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_SC_LO: begin
        mul_a = mag_r[DATA_W-1:0];
        mul_b = RTAB[m_r];
      end
      ST_SC_HI: begin
        mul_a = DATA_W'(mag_r[MAG_W-1:DATA_W]);
        mul_b = RTAB[m_r];
      end
      default: begin
        mul_a = tap_mag;
        mul_b = w_q_r;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Magnitude of the accumulator, then the rounded Q36 rescale
  assign acc_abs   = acc_r[ACC_W-1] ? (ACC_W'(0) - ACC_W'(acc_r)) : ACC_W'(acc_r);
  assign scale_sum = {prod_r, {DATA_W{1'b0}}} + SUM_W'(prod_lo_r)
                   + (SUM_W'(1) << (RND_SH - 1));
  assign res_mag   = scale_sum[RND_SH +: RES_W];
  assign avg_s     = neg_r ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  assign avg_sat   = sat32(DIFF_W'(avg_s));
  assign diff_sat  = sat32(DIFF_W'(fast_r) - DIFF_W'(avg_s));

  // Relation and crossover flags
  always_comb begin
    if (macd_r < sig_r) begin
      rel_now = REL_BELOW;
    end else if (macd_r == sig_r) begin
      rel_now = REL_EQUAL;
    end else begin
      rel_now = REL_ABOVE;
    end
    cross_dn = (rel_now == REL_BELOW)
             && ((prev_rel_r == REL_EQUAL) || (prev_rel_r == REL_ABOVE));
    cross_up = (rel_now == REL_ABOVE)
             && ((prev_rel_r == REL_BELOW) || (prev_rel_r == REL_EQUAL));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_FAST;
      prev_rel_r   <= REL_NONE;
      seen_r       <= '0;
      pwp_r        <= '0;
      gwp_r        <= '0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= (state_r == ST_ISSUE);
      s2_vld_r <= s1_vld_r;
      if (setup) begin
        phase_r <= ph_next;
      end
      // retire: result out, histories advance; otherwise drop valid on transfer
      if ((state_r == ST_FINISH) && out_free) begin
        out_tvalid_r <= 1'b1;
        prev_rel_r   <= rel_now;
        pwp_r        <= (pwp_r == P_LAST) ? '0 : pwp_r + 1'b1;
        gwp_r        <= (gwp_r == G_LAST) ? '0 : gwp_r + 1'b1;
        if (seen_r != SEEN_TOP) begin
          seen_r <= seen_r + 1'b1;
        end
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_r <= in_tdata[DATA_W-1:0];
    end

    // phase start: window, tap index, read pointers, clear accumulator
    if (setup) begin
      m_r   <= m_next;
      i_r   <= '0;
      acc_r <= '0;
      prp_r <= (pwp_r == '0) ? P_LAST : pwp_r - 1'b1;
      grp_r <= (gwp_r == '0) ? G_LAST : gwp_r - 1'b1;
    end

    // tap issue: weight ROM and history read, one tap a cycle
    w_q_r      <= WTAB[m_r][i_r];
    s1_first_r <= (i_r == '0);
    if (state_r == ST_ISSUE) begin
      if (i_r != m_r) begin
        i_r <= i_r + 1'b1;
      end
      if (i_r != '0) begin
        prp_r <= (prp_r == '0) ? P_LAST : prp_r - 1'b1;
        grp_r <= (grp_r == '0) ? G_LAST : grp_r - 1'b1;
      end
    end

    // multiply stage
    prod_r   <= mul_p;
    s2_neg_r <= tap_neg;
    if (state_r == ST_SC_HI) begin
      prod_lo_r <= prod_r;
    end

    // accumulate stage
    if (s2_vld_r) begin
      if (s2_neg_r) begin
        acc_r <= acc_r - $signed(ACC_W'(prod_r));
      end else begin
        acc_r <= acc_r + $signed(ACC_W'(prod_r));
      end
    end

    if ((state_r == ST_DRAIN) && pipe_empty) begin
      mag_r <= acc_abs[MAG_W-1:0];
      neg_r <= acc_r[ACC_W-1];
    end

    // phase results
    if (state_r == ST_SC_SUM) begin
      case (phase_r)
        PH_FAST: fast_r <= avg_s;
        PH_SLOW: macd_r <= diff_sat;
        PH_SIG:  sig_r  <= avg_sat;
        default: fast_r <= avg_s;
      endcase
    end

    if ((state_r == ST_FINISH) && out_free) begin
      out_tdata_r <= {{OUT_PAD{1'b0}}, cross_up, cross_dn, sig_r, macd_r};
    end
  end

  // Price history memory
  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      pmem[pwp_r] <= cur_r;
    end
    pmem_q_r <= pmem[prp_r];
  end

  // MACD history memory
  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      gmem[gwp_r] <= macd_r;
    end
    gmem_q_r <= gmem[grp_r];
  end

endmodule

`default_nettype wire

// ===== tb/tb_macd_signal_crossover.sv =====
// ----------------------------------------------------------------------------
// tb_macd_signal_crossover - self-checking bench for the MACD crossover block
// Streams price samples into the block and checks every result transfer
// against a cycle-free model of the fast/slow/signal averages and the
// crossover flags. Both stream sides idle at random; the sender also drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_macd_signal_crossover;

  import macd_pkg::*;

  localparam int FAST_N      = 12;
  localparam int SLOW_N      = 26;
  localparam int SIG_N       = 9;
  localparam int HIST_N      = (FAST_N > SLOW_N) ? FAST_N : SLOW_N;
  localparam int SEEN_CAP    = (HIST_N > SIG_N) ? HIST_N : SIG_N;
  localparam int PRICE_ITEMS = 1400;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYC  = 150;
  localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

  // One expected result transfer
  typedef struct {
    logic signed [DATA_W-1:0] macd_value;
    logic signed [DATA_W-1:0] signal_value;
    logic                     cross_down;
    logic                     cross_up;
  } crossover_t;

  // Tracks price and MACD history and queues the expected crossover results
  class macd_tracker;
    longint     weight [0:SEEN_CAP][0:SEEN_CAP];
    longint     recip  [0:SEEN_CAP];
    longint     taps   [0:SEEN_CAP];
    logic [31:0]              price_hist [0:HIST_N-1];
    logic signed [DATA_W-1:0] macd_hist  [0:SIG_N-1];
    int         seen;
    rel_t       last_rel;
    crossover_t pending [$];
    int         errors;

    function new();
      longint total;
      for (int m = 0; m <= SEEN_CAP; m++) begin
        for (int i = 0; i <= SEEN_CAP; i++) weight[m][i] = 0;
        weight[m][0] = 64'd262144;
        total = weight[m][0];
        if (m >= 2) begin
          for (int i = 1; i <= m; i++) begin
            weight[m][i] = (weight[m][i-1] * (m - 1) * 2 + (m + 1)) / (2 * (m + 1));
            total += weight[m][i];
          end
        end
        recip[m] = ((64'd1 << 37) / total + 1) >> 1;
      end
      foreach (price_hist[i]) price_hist[i] = '0;
      foreach (macd_hist[i]) macd_hist[i] = '0;
      seen     = 0;
      last_rel = REL_NONE;
      errors   = 0;
    endfunction

    // Normalised weighted mean of taps[0..m], rounded half away from zero
    function longint weighted_mean(int m);
      longint          acc;
      longint unsigned mag;
      logic [127:0]    scaled;
      longint          res;
      acc = 0;
      for (int i = 0; i <= m; i++) acc += weight[m][i] * taps[i];
      mag    = (acc < 0) ? longint'(-acc) : acc;
      scaled = 128'(mag) * 128'(recip[m]) + (128'd1 << 35);
      res    = longint'(scaled >> 36);
      return (acc < 0) ? -res : res;
    endfunction

    function logic signed [DATA_W-1:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[DATA_W-1:0];
    endfunction

    function longint price_mean(logic [31:0] price, int len);
      int m;
      m = (seen < len) ? seen : len;
      taps[0] = longint'({32'd0, price});
      for (int i = 1; i <= m; i++) taps[i] = longint'({32'd0, price_hist[i-1]});
      return weighted_mean(m);
    endfunction

    // Accepted price transfer: predict its result and advance the history
    function void take_price(logic [31:0] price);
      crossover_t c;
      rel_t       rel;
      int         m;
      c.macd_value = clamp32(price_mean(price, FAST_N) - price_mean(price, SLOW_N));
      m = (seen < SIG_N) ? seen : SIG_N;
      taps[0] = longint'(c.macd_value);
      for (int i = 1; i <= m; i++) taps[i] = longint'(macd_hist[i-1]);
      c.signal_value = clamp32(weighted_mean(m));

      if (c.macd_value < c.signal_value) rel = REL_BELOW;
      else if (c.macd_value == c.signal_value) rel = REL_EQUAL;
      else rel = REL_ABOVE;
      c.cross_down = (rel == REL_BELOW) && (last_rel == REL_EQUAL || last_rel == REL_ABOVE);
      c.cross_up   = (rel == REL_ABOVE) && (last_rel == REL_BELOW || last_rel == REL_EQUAL);
      last_rel = rel;

      for (int i = HIST_N - 1; i > 0; i--) price_hist[i] = price_hist[i-1];
      price_hist[0] = price;
      for (int i = SIG_N - 1; i > 0; i--) macd_hist[i] = macd_hist[i-1];
      macd_hist[0] = c.macd_value;
      if (seen < SEEN_CAP) seen++;
      pending.push_back(c);
    endfunction

    // Accepted result transfer: compare with the oldest prediction
    function void match_crossover(logic [OUT_TW-1:0] d);
      crossover_t               c;
      logic signed [DATA_W-1:0] got_macd;
      logic signed [DATA_W-1:0] got_sig;
      got_macd = d[DATA_W-1:0];
      got_sig  = d[2*DATA_W-1:DATA_W];
      if (pending.size() == 0) begin
        $error("result transfer with no prediction waiting: %h", d);
        errors++;
        return;
      end
      c = pending.pop_front();
      if (got_macd !== c.macd_value) begin
        $error("macd_value: expected %0d, got %0d", c.macd_value, got_macd);
        errors++;
      end
      if (got_sig !== c.signal_value) begin
        $error("signal_value: expected %0d, got %0d", c.signal_value, got_sig);
        errors++;
      end
      if (d[2*DATA_W] !== c.cross_down) begin
        $error("cross_down: expected %0b, got %0b", c.cross_down, d[2*DATA_W]);
        errors++;
      end
      if (d[2*DATA_W+1] !== c.cross_up) begin
        $error("cross_up: expected %0b, got %0b", c.cross_up, d[2*DATA_W+1]);
        errors++;
      end
      if (d[OUT_TW-1:2*DATA_W+2] !== '0) begin
        $error("padding: expected 0, got %h", d[OUT_TW-1:2*DATA_W+2]);
        errors++;
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  macd_tracker tracker;
  bit          calm = 1'b0;   // no idling on either side while set
  int          sent = 0;
  int          quiet = 0;

  macd_signal_crossover dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One price transfer; tvalid is only lowered when a gap is drawn
  task automatic send_price(input logic [31:0] price);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    do @(posedge clk); while (!in_tready);
    tracker.take_price(price);
    sent++;
  endtask

  // Hold the sender off until every predicted result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, check on every transfer
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.match_crossover(out_tdata);
    end
  end

  // Stimulus and end of run
  initial begin
    longint      level;
    longint      span;
    longint      slope;
    logic [31:0] price;
    int          kind;
    int          len;
    int          seg;
    tracker = new();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero then full scale on the first two samples, a square wave
    // long enough to split fast from slow, then edge values and a flat run
    send_price(32'h0000_0000);
    send_price(PRICE_MAX);
    for (int k = 0; k < 14; k++) send_price((k % 2) ? 32'h0000_0000 : PRICE_MAX);
    send_price(32'h8000_0000);
    send_price(32'h7FFF_FFFF);
    send_price(32'h0000_0001);
    send_price(32'hFFFF_FFFE);
    for (int k = 0; k < 3; k++) send_price(32'h0001_0000);
    drain_results();

    // Random segments: mostly random walks and trends, some noise and extremes
    seg = 0;
    while (sent < PRICE_ITEMS) begin
      kind  = $urandom_range(0, 9);
      len   = $urandom_range(20, 80);
      calm  = ($urandom_range(0, 3) == 0);
      level = longint'({32'd0, $urandom()});
      span  = longint'(1) << $urandom_range(4, 27);
      slope = longint'($urandom_range(1, 1 << $urandom_range(4, 26)));
      for (int k = 0; k < len && sent < PRICE_ITEMS; k++) begin
        if (kind <= 4) begin
          level += longint'($urandom_range(0, 32'(2 * span))) - span;
        end else if (kind <= 6) begin
          level += (k < len / 2) ? slope : -slope;
        end
        if (level < 0) level = 0;
        if (level > longint'({32'd0, PRICE_MAX})) level = longint'({32'd0, PRICE_MAX});
        case ($urandom_range(0, 5))
          0: price = 32'h0000_0000;
          1: price = PRICE_MAX;
          2: price = 32'h0000_0001;
          3: price = 32'hFFFF_FFFE;
          4: price = 32'h8000_0000;
          default: price = 32'h7FFF_FFFF;
        endcase
        if (kind <= 6) price = level[31:0];
        else if (kind <= 8) price = $urandom();
        send_price(price);
      end
      if (seg % 8 == 3) drain_results();
      seg++;
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (tracker.pending.size() != 0) begin
      $error("%0d predicted results never arrived", tracker.pending.size());
    end
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
